// ----- hdl/frutl_pkg.sv -----
// Shared types, constants and character helpers for the FRU type/length decoder.
`default_nettype none

package frutl_pkg;

    localparam int DataWidth  = 8;
    localparam int KindWidth  = 2;
    localparam int LenWidth   = 6;
    localparam int CarryWidth = 4;
    localparam int CcntWidth  = 3;

    // Result queue depth and the pointer/count widths that follow from it
    localparam int QueueDepth = 4;
    localparam int PtrWidth   = $clog2(QueueDepth);
    localparam int CntWidth   = $clog2(QueueDepth + 1);

    // Header byte fields
    localparam logic [DataWidth-1:0] HdrKindMask = 8'hC0;
    localparam logic [DataWidth-1:0] HdrLenMask  = 8'h3F;

    // Field type codes
    typedef enum logic [KindWidth-1:0] {
        KIND_BINARY = 2'd0,
        KIND_BCD    = 2'd1,
        KIND_SIX    = 2'd2,
        KIND_ASCII8 = 2'd3
    } t_kind;

    // Packed-ASCII carry counts
    localparam logic [CcntWidth-1:0] CarryNone = 3'd0;
    localparam logic [CcntWidth-1:0] CarryTwo  = 3'd2;
    localparam logic [CcntWidth-1:0] CarryFour = 3'd4;

    // Printable range and character codes
    localparam logic [DataWidth-1:0] CharSpace = 8'h20;
    localparam logic [DataWidth-1:0] CharTilde = 8'h7E;
    localparam logic [DataWidth-1:0] CharZero  = 8'h30;
    localparam logic [DataWidth-1:0] CharDash  = 8'h2D;
    localparam logic [DataWidth-1:0] CharDot   = 8'h2E;
    localparam logic [DataWidth-1:0] CharNul   = 8'h00;

    // BCD-plus codes above the digits
    localparam logic [DataWidth-1:0] BcdSpace = 8'h0A;
    localparam logic [DataWidth-1:0] BcdDash  = 8'h0B;
    localparam logic [DataWidth-1:0] BcdDot   = 8'h0C;

    typedef struct packed {
        logic [DataWidth-1:0] character;
        logic                 char_valid;
        logic                 field_done;
        logic                 illegal_char;
        logic [KindWidth-1:0] field_kind;
    } t_result;

    // Map one BCD-plus byte to its character, NUL for unused codes
    function automatic logic [DataWidth-1:0] bcd_plus(input logic [DataWidth-1:0] b);
        logic [DataWidth-1:0] ch;
        begin
            if (b < BcdSpace) begin
                ch = b + CharZero;
            end else if (b == BcdSpace) begin
                ch = CharSpace;
            end else if (b == BcdDash) begin
                ch = CharDash;
            end else if (b == BcdDot) begin
                ch = CharDot;
            end else begin
                ch = CharNul;
            end
            return ch;
        end
    endfunction

    // Build one result and flag characters outside the printable range
    function automatic t_result make_result(input logic [DataWidth-1:0] ch,
                                            input logic valid,
                                            input logic done,
                                            input logic [KindWidth-1:0] kind);
        t_result r;
        begin
            r.character    = ch;
            r.char_valid   = valid;
            r.field_done   = done;
            r.illegal_char = (ch != CharNul) && ((ch < CharSpace) || (ch > CharTilde));
            r.field_kind   = kind;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fru_type_length_string_decoder_core.sv -----
// Top level: FRU type/length field decoder with a four-entry result queue.
`default_nettype none

// Takes one FRU area byte per beat and returns decoded characters, one result beat per
// cycle while i_ready is high. A byte is accepted in every cycle while the result queue
// has room for two results; it is decoded in the same cycle and its results are written
// to the queue, from which they reach the output in order behind earlier results.
// Header bytes with a non-zero length give no result, binary, BCD-plus and 8-bit field
// bytes give one, and six-bit packed bytes give one or two (two for the third byte of
// every group of three). The single output port sets the sustained rate, so a run of
// six-bit packed bytes, four results per three bytes, is taken in more slowly than its
// results leave. A zero-length field gives one result, char_valid low, field_done high.
module fru_type_length_string_decoder_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [frutl_pkg::DataWidth-1:0]  i_data_byte,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [frutl_pkg::DataWidth-1:0]  o_character,
    output logic                             o_char_valid,
    output logic                             o_field_done,
    output logic                             o_illegal_char,
    output logic [frutl_pkg::KindWidth-1:0]  o_field_kind
);
    import frutl_pkg::*;

    // Decoder state
    logic                  r_expect_header, n_expect_header;
    logic [KindWidth-1:0]  r_current_kind,  n_current_kind;
    logic [LenWidth-1:0]   r_bytes_left,    n_bytes_left;
    logic [CarryWidth-1:0] r_carry_bits,    n_carry_bits;
    logic [CcntWidth-1:0]  r_carry_count,   n_carry_count;

    // Result queue
    t_result               r_queue [QueueDepth];
    logic [PtrWidth-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrWidth-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CntWidth-1:0]   r_count,  n_count;

    logic                  in_beat;
    logic                  out_beat;
    logic [1:0]            wr_num;
    t_result               res0;
    t_result               res1;

    logic                  is_header;
    logic [KindWidth-1:0]  hdr_kind;
    logic [LenWidth-1:0]   hdr_len;
    logic                  last_byte;
    logic [5:0]            six0;
    logic [5:0]            six1;
    logic [LenWidth-1:0]   left_dec;

    assign o_ready  = (r_count <= CntWidth'(QueueDepth - 2));
    assign in_beat  = i_valid && o_ready;
    assign o_valid  = (r_count != '0);
    assign out_beat = o_valid && i_ready;

    assign o_character    = r_queue[r_rd_ptr].character;
    assign o_char_valid   = r_queue[r_rd_ptr].char_valid;
    assign o_field_done   = r_queue[r_rd_ptr].field_done;
    assign o_illegal_char = r_queue[r_rd_ptr].illegal_char;
    assign o_field_kind   = r_queue[r_rd_ptr].field_kind;

    assign is_header = r_expect_header || (r_bytes_left == '0);
    assign hdr_kind  = KindWidth'((i_data_byte & HdrKindMask) >> 6);
    assign hdr_len   = LenWidth'(i_data_byte & HdrLenMask);
    assign last_byte = (r_bytes_left == LenWidth'(1));
    assign left_dec  = r_bytes_left - LenWidth'(1);

    // Decode the incoming byte against the current field state
    always_comb begin
        n_expect_header = r_expect_header;
        n_current_kind  = r_current_kind;
        n_bytes_left    = r_bytes_left;
        n_carry_bits    = r_carry_bits;
        n_carry_count   = r_carry_count;
        wr_num          = 2'd0;
        res0            = '0;
        res1            = '0;
        six0            = '0;
        six1            = '0;

        if (is_header) begin
            n_current_kind = hdr_kind;
            n_carry_bits   = '0;
            n_carry_count  = CarryNone;
            if (hdr_len == '0) begin
                n_expect_header = 1'b1;
                n_bytes_left    = '0;
                res0            = make_result(CharNul, 1'b0, 1'b1, hdr_kind);
                wr_num          = 2'd1;
            end else begin
                n_expect_header = 1'b0;
                n_bytes_left    = hdr_len;
            end
        end else begin
            unique case (r_current_kind)
                KIND_BCD: begin
                    res0   = make_result(bcd_plus(i_data_byte), 1'b1, last_byte,
                                         r_current_kind);
                    wr_num = 2'd1;
                end
                KIND_SIX: begin
                    priority if (r_carry_count == CarryTwo) begin
                        six0          = {i_data_byte[3:0], r_carry_bits[1:0]};
                        res0          = make_result({2'b00, six0} + CharSpace, 1'b1,
                                                    last_byte, r_current_kind);
                        n_carry_bits  = i_data_byte[7:4];
                        n_carry_count = CarryFour;
                        wr_num        = 2'd1;
                    end else if (r_carry_count == CarryFour) begin
                        six0          = {i_data_byte[1:0], r_carry_bits};
                        six1          = i_data_byte[7:2];
                        res0          = make_result({2'b00, six0} + CharSpace, 1'b1, 1'b0,
                                                    r_current_kind);
                        res1          = make_result({2'b00, six1} + CharSpace, 1'b1,
                                                    last_byte, r_current_kind);
                        n_carry_bits  = '0;
                        n_carry_count = CarryNone;
                        wr_num        = 2'd2;
                    end else begin
                        six0          = i_data_byte[5:0];
                        res0          = make_result({2'b00, six0} + CharSpace, 1'b1,
                                                    last_byte, r_current_kind);
                        n_carry_bits  = {2'b00, i_data_byte[7:6]};
                        n_carry_count = CarryTwo;
                        wr_num        = 2'd1;
                    end
                end
                default: begin
                    res0   = make_result(i_data_byte, 1'b1, last_byte, r_current_kind);
                    wr_num = 2'd1;
                end
            endcase
            n_bytes_left = left_dec;
            if (left_dec == '0) begin
                n_expect_header = 1'b1;
                n_carry_bits    = '0;
                n_carry_count   = CarryNone;
            end
        end
    end

    // Advance the decoder state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_current_kind  <= '0;
            r_bytes_left    <= '0;
            r_carry_bits    <= '0;
            r_carry_count   <= CarryNone;
        end else if (in_beat) begin
            r_expect_header <= n_expect_header;
            r_current_kind  <= n_current_kind;
            r_bytes_left    <= n_bytes_left;
            r_carry_bits    <= n_carry_bits;
            r_carry_count   <= n_carry_count;
        end
    end

    // Queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (in_beat) begin
            n_wr_ptr = r_wr_ptr + PtrWidth'(wr_num);
            n_count  = n_count + CntWidth'(wr_num);
        end
        if (out_beat) begin
            n_rd_ptr = r_rd_ptr + PtrWidth'(1);
            n_count  = n_count - CntWidth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write up to two results per beat into the queue
    always_ff @(posedge i_clk) begin
        if (in_beat && (wr_num != 2'd0)) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_beat && (wr_num == 2'd2)) begin
            r_queue[r_wr_ptr + PtrWidth'(1)] <= res1;
        end
    end

`ifndef SYNTHESIS
    // Queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntWidth'(QueueDepth))
        else $error("result queue overfilled");

    // A beat that writes results makes the output valid in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (wr_num != 2'd0)) |=> o_valid)
        else $error("decoded result did not reach the output");

    // An empty-field result is always the end of its field, with no character
    a_empty_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_valid) |-> (o_field_done && (o_character == CharNul)
                                        && !o_illegal_char))
        else $error("malformed empty-field result");

    // The two-result case only arises for six-bit fields with four carried bits
    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (wr_num == 2'd2)) |-> ((r_current_kind == KIND_SIX)
                                           && (r_carry_count == CarryFour)))
        else $error("unexpected double result");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_fru_type_length_string_decoder_core.sv -----
// Testbench for the FRU type/length field decoder: byte stream in, checked character beats out.
`default_nettype none

module tb_fru_type_length_string_decoder_core;

    import frutl_pkg::*;

    localparam int StallLimit  = 2000;
    localparam int HoldCycles  = 80;
    localparam int HoldAtBeat  = 60;
    localparam int PhaseItems  = 125;
    localparam int DrainCycles = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [DataWidth-1:0] i_data_byte = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [DataWidth-1:0] o_character;
    logic                 o_char_valid;
    logic                 o_field_done;
    logic                 o_illegal_char;
    logic [KindWidth-1:0] o_field_kind;

    fru_type_length_string_decoder_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_character    (o_character),
        .o_char_valid   (o_char_valid),
        .o_field_done   (o_field_done),
        .o_illegal_char (o_illegal_char),
        .o_field_kind   (o_field_kind)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting to be sent and decoded characters waiting to arrive
    logic [DataWidth-1:0] pending_bytes[$];
    t_result              expected_chars[$];

    // Decoder state as predicted
    logic                  at_header;
    t_kind                 field_type;
    logic [LenWidth-1:0]   bytes_to_go;
    logic [CarryWidth-1:0] packed_carry;
    logic [CcntWidth-1:0]  carry_bits_n;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int fail_count = 0;
    int bytes_accepted = 0;
    int beats_checked = 0;
    int fields_seen = 0;
    int pair_bytes = 0;
    int illegal_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;
    t_result got_char;

    // Queue one expected character beat, flagging anything outside the printable range
    function automatic void expect_char(input logic [DataWidth-1:0] ch, input logic valid,
                                        input logic done, input t_kind kind);
        t_result r;
        r.character    = ch;
        r.char_valid   = valid;
        r.field_done   = done;
        r.illegal_char = (ch != CharNul) && ((ch < CharSpace) || (ch > CharTilde));
        r.field_kind   = kind;
        expected_chars.push_back(r);
    endfunction

    // Advance the predicted decoder by one accepted byte
    function automatic void decode_byte(input logic [DataWidth-1:0] b);
        logic [LenWidth-1:0]  len;
        logic                 last;
        logic [DataWidth-1:0] ch;
        len = LenWidth'(b & HdrLenMask);
        if (at_header || bytes_to_go == '0) begin
            field_type   = t_kind'(KindWidth'((b & HdrKindMask) >> LenWidth));
            packed_carry = '0;
            carry_bits_n = CarryNone;
            fields_seen++;
            bytes_to_go  = len;
            at_header    = (len == '0);
            if (len == '0) begin
                expect_char(CharNul, 1'b0, 1'b1, field_type);
            end
            return;
        end
        last = (bytes_to_go == 1);
        case (field_type)
            KIND_BCD: begin
                if (b < BcdSpace) ch = b + CharZero;
                else if (b == BcdSpace) ch = CharSpace;
                else if (b == BcdDash) ch = CharDash;
                else if (b == BcdDot) ch = CharDot;
                else ch = CharNul;
                expect_char(ch, 1'b1, last, field_type);
            end
            KIND_SIX: begin
                if (carry_bits_n == CarryTwo) begin
                    expect_char({2'b00, b[3:0], packed_carry[1:0]} + CharSpace, 1'b1, last,
                                field_type);
                    packed_carry = b[7:4];
                    carry_bits_n = CarryFour;
                end else if (carry_bits_n == CarryFour) begin
                    expect_char({2'b00, b[1:0], packed_carry} + CharSpace, 1'b1, 1'b0,
                                field_type);
                    expect_char({2'b00, b[7:2]} + CharSpace, 1'b1, last, field_type);
                    packed_carry = '0;
                    carry_bits_n = CarryNone;
                    pair_bytes++;
                end else begin
                    expect_char({2'b00, b[5:0]} + CharSpace, 1'b1, last, field_type);
                    packed_carry = {2'b00, b[7:6]};
                    carry_bits_n = CarryTwo;
                end
            end
            default: begin
                expect_char(b, 1'b1, last, field_type);
            end
        endcase
        bytes_to_go = bytes_to_go - 1'b1;
        if (bytes_to_go == '0) begin
            at_header    = 1'b1;
            packed_carry = '0;
            carry_bits_n = CarryNone;
        end
    endfunction

    function automatic logic [DataWidth-1:0] header_byte(input t_kind kind, input int len);
        return {kind, len[LenWidth-1:0]};
    endfunction

    // Queue whole fields of random type, length and content
    task automatic add_random_fields(input int n_items);
        int    queued;
        int    len;
        int    r;
        t_kind kind;
        queued = 0;
        while (queued < n_items) begin
            kind = t_kind'($urandom_range(3));
            r    = $urandom_range(99);
            if (r < 10) len = 0;
            else if (r < 94) len = $urandom_range(9, 1);
            else len = $urandom_range(63, 10);
            pending_bytes.push_back(header_byte(kind, len));
            queued++;
            repeat (len) begin
                if (kind == KIND_BCD && $urandom_range(3) != 0) begin
                    pending_bytes.push_back(DataWidth'($urandom_range(12)));
                end else begin
                    pending_bytes.push_back(DataWidth'($urandom_range(255)));
                end
                queued++;
            end
        end
    endtask

    // Wait until every queued byte is sent and every expected beat has come back
    task automatic drain_all();
        while (pending_bytes.size() != 0 || i_valid || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Sender: predict on each accepted beat, then offer the next byte or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_data_byte <= '0;
            at_header    = 1'b1;
            field_type   = KIND_BINARY;
            bytes_to_go  = '0;
            packed_carry = '0;
            carry_bits_n = CarryNone;
        end else begin
            if (i_valid && o_ready) begin
                decode_byte(i_data_byte);
                bytes_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_valid     <= 1'b1;
                    i_data_byte <= pending_bytes.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result beat against the oldest expectation, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                beats_checked++;
                if (o_illegal_char) illegal_seen++;
                if (expected_chars.size() == 0) begin
                    $error("unexpected result beat: character %0h", o_character);
                    fail_count++;
                end else begin
                    got_char = expected_chars.pop_front();
                    if (o_character !== got_char.character) begin
                        $error("character: expected %0h, got %0h",
                               got_char.character, o_character);
                        fail_count++;
                    end
                    if (o_char_valid !== got_char.char_valid) begin
                        $error("char_valid: expected %0b, got %0b",
                               got_char.char_valid, o_char_valid);
                        fail_count++;
                    end
                    if (o_field_done !== got_char.field_done) begin
                        $error("field_done: expected %0b, got %0b",
                               got_char.field_done, o_field_done);
                        fail_count++;
                    end
                    if (o_illegal_char !== got_char.illegal_char) begin
                        $error("illegal_char: expected %0b, got %0b",
                               got_char.illegal_char, o_illegal_char);
                        fail_count++;
                    end
                    if (o_field_kind !== got_char.field_kind) begin
                        $error("field_kind: expected %0d, got %0d",
                               got_char.field_kind, o_field_kind);
                        fail_count++;
                    end
                end
            end
            // Hold off once for a long stretch so the result queue fills and input stalls
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && beats_checked >= HoldAtBeat) begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("timeout: no beat for %0d cycles", StallLimit);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty fields of every type
        pending_bytes.push_back(header_byte(KIND_BINARY, 0));
        pending_bytes.push_back(header_byte(KIND_BCD, 0));
        pending_bytes.push_back(header_byte(KIND_SIX, 0));
        pending_bytes.push_back(header_byte(KIND_ASCII8, 0));
        // BCD-plus: digit extremes, space, dash, dot and an unused code
        pending_bytes.push_back(header_byte(KIND_BCD, 6));
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h09);
        pending_bytes.push_back(BcdSpace);
        pending_bytes.push_back(BcdDash);
        pending_bytes.push_back(BcdDot);
        pending_bytes.push_back(8'hFF);
        // Six-bit packed: a full group of three, then a fourth byte that ends the field mid-group
        pending_bytes.push_back(header_byte(KIND_SIX, 4));
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hC5);
        // Binary: NUL and a byte far outside the printable range
        pending_bytes.push_back(header_byte(KIND_BINARY, 2));
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        // 8-bit: both edges of the printable range
        pending_bytes.push_back(header_byte(KIND_ASCII8, 4));
        pending_bytes.push_back(8'h1F);
        pending_bytes.push_back(CharSpace);
        pending_bytes.push_back(CharTilde);
        pending_bytes.push_back(8'h7F);
        drain_all();

        tx_idle_pct = 9;
        rx_idle_pct = 58;
        add_random_fields(PhaseItems);
        drain_all();

        tx_idle_pct = 58;
        rx_idle_pct = 9;
        add_random_fields(PhaseItems);
        drain_all();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_fields(PhaseItems);
        drain_all();

        repeat (DrainCycles) @(negedge i_clk);
        $display("Sent %0d bytes in %0d fields; %0d packed bytes gave character pairs.",
                 bytes_accepted, fields_seen, pair_bytes);
        $display("Checked %0d result beats, %0d flagged illegal, %0d mismatches.",
                 beats_checked, illegal_seen, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
